// ----- hdl/lmea_pkg.sv -----
`timescale 1ns / 1ps

package lmea_pkg;

  // field and register widths
  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 32;
  localparam int BTP_W      = 32;
  localparam int DAMP_W     = 16;
  localparam int ERR_SUM_W  = 48;
  localparam int POS_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 144;

  // default coefficient fraction bits, signed Q2.F
  localparam int COEF_FRAC_BITS_DEF = 30;

  // bandwidth times period is Q8.24, damping is Q4.12
  localparam int X_FRAC = 24;
  localparam int Z_FRAC = 12;
  localparam int X2_W   = 40;
  localparam int ZX4_W  = 38;

  // divider datapath, holds numerators up to twice the denominator
  localparam int DIV_W = 44;

  // shared multiplier operands and accumulator
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 35;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  // accumulator operations
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_SUB  = 2'd2;

  // register reset values
  localparam logic [BTP_W-1:0]  RST_BTP  = BTP_W'(1677722);
  localparam logic [DAMP_W-1:0] RST_DAMP = DAMP_W'(2896);

  // Q8.24 constants of the coefficient formulas
  localparam logic [DIV_W-1:0] Q24_TWO   = DIV_W'(2) << X_FRAC;
  localparam logic [DIV_W-1:0] Q24_FOUR  = DIV_W'(4) << X_FRAC;
  localparam logic [DIV_W-1:0] Q24_EIGHT = DIV_W'(8) << X_FRAC;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic       en;
    logic [1:0] op;
  } mac_cmd_t;

endpackage

// ----- hdl/lmea_div.sv -----
`timescale 1ns / 1ps

module lmea_div #(
  parameter int COEF_FRAC_BITS = lmea_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start_i,
  input  logic signed [lmea_pkg::DIV_W-1:0]   num_i,
  input  logic        [lmea_pkg::DIV_W-1:0]   den_i,
  output logic                                done_o,
  output lmea_pkg::coef_t                     coef_o
);
  import lmea_pkg::*;

  // two integer bits then the fraction bits, one quotient bit a cycle
  localparam int STEPS = COEF_FRAC_BITS + 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);
  localparam logic [CNT_W-1:0] FIRST_FRAC = CNT_W'(2);
  localparam logic [COEF_W-1:0] MIN_MAG = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  den_r;
  logic [COEF_W-1:0] q_r;
  logic              neg_r;

  logic [DIV_W-1:0]  rem_sh;
  logic [DIV_W-1:0]  cmp_val;
  logic              ge;
  logic [DIV_W-1:0]  rem_nxt;

  // one restoring step: first against twice the divisor, then the divisor, then shift and compare
  always_comb begin
    rem_sh  = (cnt_r >= FIRST_FRAC) ? {rem_r[DIV_W-2:0], 1'b0} : rem_r;
    cmp_val = (cnt_r == '0) ? {den_r[DIV_W-2:0], 1'b0} : den_r;
    ge      = (rem_sh >= cmp_val);
    rem_nxt = ge ? (rem_sh - cmp_val) : rem_sh;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_STEP);
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= num_i[DIV_W-1];
      rem_r <= num_i[DIV_W-1] ? DIV_W'(-num_i) : DIV_W'(num_i);
      den_r <= den_i;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[COEF_W-2:0], ge};
    end
  end

  // apply sign and clamp to the signed coefficient range
  always_comb begin
    if (!neg_r) begin
      coef_o = q_r[COEF_W-1] ? COEF_MAX : coef_t'(q_r);
    end else if (q_r > MIN_MAG) begin
      coef_o = COEF_MIN;
    end else begin
      coef_o = coef_t'(-q_r);
    end
  end

  assign done_o = done_r;

endmodule

// ----- hdl/lmea_mac.sv -----
`timescale 1ns / 1ps

module lmea_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lmea_pkg::mac_cmd_t                  cmd_i,
  input  logic signed [lmea_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [lmea_pkg::MUL_B_W-1:0] b_i,
  output logic signed [lmea_pkg::PROD_W-1:0]  prod_o,
  output logic signed [lmea_pkg::ACC_W-1:0]   acc_o
);
  import lmea_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [1:0]               op_r;

  // pending accumulator operation, applied in the cycle after its product is registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= ACC_NONE;
    end else begin
      op_r <= cmd_i.en ? cmd_i.op : ACC_NONE;
    end
  end

  // registered product, then accumulate
  always_ff @(posedge clk) begin
    if (cmd_i.en) begin
      prod_r <= PROD_W'(a_i) * PROD_W'(b_i);
    end
    unique case (op_r)
      ACC_LOAD: acc_r <= ACC_W'(prod_r);
      ACC_SUB:  acc_r <= acc_r - ACC_W'(prod_r);
      default:  acc_r <= acc_r;
    endcase
  end

  assign prod_o = prod_r;
  assign acc_o  = acc_r;

endmodule

// ----- hdl/lowpass_model_error_accumulator.sv -----
`timescale 1ns / 1ps

// Lowpass model error accumulator.
// Input channel in_*: one word per sample, stimulus and measured response in Q16.16,
// tuser marks record start and run start, tlast marks the end of the run.
// Output channel out_*: one word per input word, modelled value, absolute error,
// running error sum (saturating at 48 bits) and error peak of the run; tlast copies
// the run end flag of the input word.
// Configuration channel cfg_*: order, bandwidth times period (Q8.24) and damping
// (Q4.12); values are picked up at the next run start.
// A sample that copies the measured value goes straight to the result step; a filtered
// sample makes three passes through the one shared multiplier and accumulator, then
// saturation and error update. A run start word also derives the coefficients through
// a bit-serial divider that is started anew for each coefficient.
// in_tready is high only while no sample is in work.
// Reset clears filter history, error totals and the configuration to its defaults;
// coefficients are undefined until the first run start.
// The result sits in an output register; a new sample is taken while it waits, and
// the next result holds in its last step until out_tready frees the register.
module lowpass_model_error_accumulator #(
  parameter int COEF_FRAC_BITS = lmea_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // stimulus, measured
  input  logic [lmea_pkg::IN_DATA_W-1:0]    in_tdata,
  // record_start, run_start
  input  logic [lmea_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // modelled, abs_error, error_total, error_peak
  output logic [lmea_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lmea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmea_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lmea_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_ZX    = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_DEN   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_M0    = 4'd7;
  localparam logic [3:0] S_M1    = 4'd8;
  localparam logic [3:0] S_M2    = 4'd9;
  localparam logic [3:0] S_W1    = 4'd10;
  localparam logic [3:0] S_Y     = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BTP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 2'd2;

  // coefficient slots
  localparam logic [1:0] COEF_A  = 2'd0;
  localparam logic [1:0] COEF_B1 = 2'd1;
  localparam logic [1:0] COEF_B2 = 2'd2;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TWO = POS_W'(2);

  localparam logic signed [SAMPLE_W-1:0] Y_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] Y_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [ERR_SUM_W-1:0] SUM_MAX = {ERR_SUM_W{1'b1}};

  // configuration registers
  logic                 cfg_order_r;
  logic [BTP_W-1:0]     cfg_x_r;
  logic [DAMP_W-1:0]    cfg_z_r;

  // sequencer and run state
  logic [3:0]           state_r, state_nxt;
  logic                 ord_r;
  logic [1:0]           coef_idx_r;
  logic [POS_W-1:0]     pos_r;
  logic signed [SAMPLE_W-1:0] s1_r, s2_r, y1_r, y2_r;
  logic [ERR_SUM_W-1:0] err_sum_r;
  logic [SAMPLE_W-1:0]  err_max_r;

  // sample in work
  logic signed [SAMPLE_W-1:0] stim_r, meas_r, y_r;
  logic                 end_r;

  // coefficient derivation
  logic [X2_W-1:0]      x2_r;
  logic [ZX4_W-1:0]     zx4_r;
  logic [DIV_W-1:0]     den_r;
  coef_t                coef0_r, coef1_r, coef2_r;

  // output register
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 out_last_r;
  logic [SAMPLE_W-1:0]  out_abs_r, out_peak_r;

  // input word fields
  logic signed [SAMPLE_W-1:0] stim_in, meas_in;
  logic                 rec_in, run_in, in_accept;
  logic                 rec_eff, ord_eff, copy_eff;
  logic [POS_W-1:0]     pos_eff;

  assign stim_in   = in_tdata[SAMPLE_W-1:0];
  assign meas_in   = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign rec_in    = in_tuser[0];
  assign run_in    = in_tuser[1];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // first one or two samples of a record copy the measured value
  always_comb begin
    rec_eff  = rec_in || run_in;
    ord_eff  = run_in ? cfg_order_r : ord_r;
    pos_eff  = rec_eff ? '0 : pos_r;
    copy_eff = (pos_eff == '0) || (ord_eff && (pos_eff == POS_ONE));
  end

  // shared divider
  logic                     div_start, div_done;
  logic signed [DIV_W-1:0]  div_num;
  coef_t                    div_coef;

  assign div_start = (state_r == S_DIV);

  // numerator for the coefficient in work
  always_comb begin
    case (coef_idx_r)
      COEF_A:  div_num = ord_r ? signed'(DIV_W'(x2_r)) : signed'(DIV_W'(cfg_x_r));
      COEF_B1: div_num = ord_r ? signed'((DIV_W'(x2_r) << 1) - Q24_EIGHT)
                               : signed'(DIV_W'(cfg_x_r) - Q24_TWO);
      default: div_num = signed'(Q24_FOUR + DIV_W'(x2_r) - DIV_W'(zx4_r));
    endcase
  end

  lmea_div #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (den_r),
    .done_o (div_done),
    .coef_o (div_coef)
  );

  // shared multiplier and accumulator
  mac_cmd_t                   mac_cmd;
  logic signed [MUL_A_W-1:0]  mac_a;
  logic signed [MUL_B_W-1:0]  mac_b;
  logic signed [PROD_W-1:0]   mac_prod;
  logic signed [ACC_W-1:0]    mac_acc;
  logic signed [MUL_B_W-1:0]  ssum;

  // stimulus tap sum of the recursion
  always_comb begin
    if (ord_r) begin
      ssum = MUL_B_W'(stim_r) + (MUL_B_W'(s1_r) <<< 1) + MUL_B_W'(s2_r);
    end else begin
      ssum = MUL_B_W'(stim_r) + MUL_B_W'(s1_r);
    end
  end

  // multiplier operands by step
  always_comb begin
    mac_cmd.en = 1'b0;
    mac_cmd.op = ACC_NONE;
    mac_a      = '0;
    mac_b      = '0;
    case (state_r)
      S_SQ: begin
        mac_cmd.en = 1'b1;
        mac_a      = signed'(MUL_A_W'(cfg_x_r));
        mac_b      = signed'(MUL_B_W'(cfg_x_r));
      end
      S_ZX: begin
        mac_cmd.en = 1'b1;
        mac_a      = signed'(MUL_A_W'(cfg_z_r));
        mac_b      = signed'(MUL_B_W'(cfg_x_r));
      end
      S_M0: begin
        mac_cmd.en = 1'b1;
        mac_cmd.op = ACC_LOAD;
        mac_a      = MUL_A_W'(coef0_r);
        mac_b      = ssum;
      end
      S_M1: begin
        mac_cmd.en = 1'b1;
        mac_cmd.op = ACC_SUB;
        mac_a      = MUL_A_W'(coef1_r);
        mac_b      = MUL_B_W'(y1_r);
      end
      S_M2: begin
        mac_cmd.en = 1'b1;
        mac_cmd.op = ACC_SUB;
        mac_a      = MUL_A_W'(coef2_r);
        mac_b      = MUL_B_W'(y2_r);
      end
      default: begin
      end
    endcase
  end

  lmea_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (mac_cmd),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .prod_o(mac_prod),
    .acc_o (mac_acc)
  );

  // floor shift of the recursion sum and saturation
  logic signed [ACC_W-1:0]    y_full;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic [ACC_W-COEF_W:0]      y_top;

  always_comb begin
    y_full = mac_acc >>> COEF_FRAC_BITS;
    y_top  = y_full[ACC_W-1:SAMPLE_W-1];
    if ((&y_top) || !(|y_top)) begin
      y_sat = y_full[SAMPLE_W-1:0];
    end else begin
      y_sat = y_full[ACC_W-1] ? Y_MIN : Y_MAX;
    end
  end

  // error against the measured value
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          diff_abs;
  logic [SAMPLE_W-1:0]        err;
  logic [ERR_SUM_W:0]         sum_add;
  logic [ERR_SUM_W-1:0]       sum_nxt;
  logic [SAMPLE_W-1:0]        max_nxt;
  logic                       fin_go;

  always_comb begin
    diff     = (SAMPLE_W+1)'(meas_r) - (SAMPLE_W+1)'(y_r);
    diff_abs = diff[SAMPLE_W] ? unsigned'(-diff) : unsigned'(diff);
    err      = diff_abs[SAMPLE_W-1:0];
    sum_add  = {1'b0, err_sum_r} + (ERR_SUM_W+1)'(err);
    sum_nxt  = sum_add[ERR_SUM_W] ? SUM_MAX : sum_add[ERR_SUM_W-1:0];
    max_nxt  = (err > err_max_r) ? err : err_max_r;
    fin_go   = (state_r == S_FIN) && (!out_valid_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (run_in) begin
            state_nxt = cfg_order_r ? S_SQ : S_DEN;
          end else begin
            state_nxt = copy_eff ? S_FIN : S_M0;
          end
        end
      end
      S_SQ:    state_nxt = S_ZX;
      S_ZX:    state_nxt = S_PREP;
      S_PREP:  state_nxt = S_DEN;
      S_DEN:   state_nxt = S_DIV;
      S_DIV:   state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          if (coef_idx_r == (ord_r ? COEF_B2 : COEF_B1)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_W1;
      S_W1:    state_nxt = S_Y;
      S_Y:     state_nxt = S_FIN;
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, history and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_order_r <= 1'b1;
      cfg_x_r     <= RST_BTP;
      cfg_z_r     <= RST_DAMP;
      ord_r       <= 1'b1;
      coef_idx_r  <= COEF_A;
      pos_r       <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      err_sum_r   <= '0;
      err_max_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ORDER: cfg_order_r <= cfg_data[0];
          REG_BTP:   cfg_x_r     <= cfg_data[BTP_W-1:0];
          REG_DAMP:  cfg_z_r     <= cfg_data[DAMP_W-1:0];
          default: begin
          end
        endcase
      end

      // new sample: record and run starts
      if (in_accept) begin
        if (run_in) begin
          ord_r     <= cfg_order_r;
          err_sum_r <= '0;
          err_max_r <= '0;
        end
        if (rec_eff) begin
          pos_r <= '0;
          s1_r  <= '0;
          s2_r  <= '0;
          y1_r  <= '0;
          y2_r  <= '0;
        end
      end

      // coefficient slot counter
      if (state_r == S_DEN) begin
        coef_idx_r <= COEF_A;
      end else if ((state_r == S_DWAIT) && div_done) begin
        coef_idx_r <= coef_idx_r + 2'd1;
      end

      // finish sample: shift history, update totals
      if (fin_go) begin
        s2_r      <= s1_r;
        s1_r      <= stim_r;
        y2_r      <= y1_r;
        y1_r      <= y_r;
        err_sum_r <= sum_nxt;
        err_max_r <= max_nxt;
        if (pos_r != POS_TWO) begin
          pos_r <= pos_r + POS_ONE;
        end
      end

      // output handshake
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stim_r <= stim_in;
      meas_r <= meas_in;
      end_r  <= in_tlast;
      if (run_in || copy_eff) begin
        y_r <= meas_in;
      end
    end
    if (state_r == S_Y) begin
      y_r <= y_sat;
    end
    if (state_r == S_ZX) begin
      x2_r <= mac_prod[X_FRAC +: X2_W];
    end
    if (state_r == S_PREP) begin
      zx4_r <= {mac_prod[Z_FRAC +: ZX4_W-2], 2'b00};
    end
    if (state_r == S_DEN) begin
      if (ord_r) begin
        den_r <= Q24_FOUR + DIV_W'(zx4_r) + DIV_W'(x2_r);
      end else begin
        den_r   <= DIV_W'(cfg_x_r) + Q24_TWO;
        coef2_r <= '0;
      end
    end
    if ((state_r == S_DWAIT) && div_done) begin
      case (coef_idx_r)
        COEF_A:  coef0_r <= div_coef;
        COEF_B1: coef1_r <= div_coef;
        default: coef2_r <= div_coef;
      endcase
    end
    if (fin_go) begin
      out_data_r <= {max_nxt, sum_nxt, err, y_r};
      out_last_r <= end_r;
      out_abs_r  <= err;
      out_peak_r <= max_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd3)
    else $error("sample position out of range");

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && run_in) |=> (err_sum_r == '0 && err_max_r == '0))
    else $error("run start did not clear error totals");

  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_peak_r >= out_abs_r))
    else $error("error peak below current error");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWAIT))
    else $error("divider finished outside coefficient step");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_tready) |=> (state_r == S_FIN))
    else $error("result step left while output register full");

endmodule
